### src/assert_macros.svh
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define BTH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define BTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/bth_pkg.sv
// ----------------------------------------------------------------------------
// Block table heap allocator package
// Shared types, codes and default sizes.
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int unsigned MAX_BLOCKS_DEF  = 1024;
  localparam int unsigned BLOCK_BYTES_DEF = 4096;

  // One table entry: has-next, first, taken.
  typedef struct packed {
    logic has_next;
    logic first;
    logic taken;
  } entry_t;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;

  localparam logic [7:0] REG_BASE_ADDRESS = 8'd0;
  localparam logic [7:0] REG_BLOCK_COUNT  = 8'd1;

  localparam logic [10:0] BLOCK_COUNT_RST = 11'd1024;

endpackage

### src/bth_if.sv
// ----------------------------------------------------------------------------
// Block table heap allocator channels
// Request, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bth_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] size_bytes;
  logic [31:0] address;
  modport source (output valid, func, size_bytes, address, input ready);
  modport sink   (input valid, func, size_bytes, address, output ready);
endinterface

interface bth_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_address;
  logic [31:0] used_bytes;
  modport source (output valid, status, alloc_address, used_bytes, input ready);
  modport sink   (input valid, status, alloc_address, used_bytes, output ready);
endinterface

interface bth_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/bth_cell.sv
// ----------------------------------------------------------------------------
// Block table cell
// Holds one table entry and takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module bth_cell
  import bth_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

### src/block_table_heap_allocator.sv
// ----------------------------------------------------------------------------
// Block table heap allocator
// First-fit allocator over a ring of block table cells.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  in_i    | in  | func, size_bytes, address
//  out_o   | out | status, alloc_address, used_bytes
//  cfg_i   | in  | index, data (0 base address, 1 block count)
//
// The table is a ring of MAX_BLOCKS cells that rotates one place per cycle
// while a request is worked on; the controller reads and rewrites the entry
// at the head of the ring. An allocate takes a full rotation to search and, if
// a run is found, a second to mark it; a free or a query takes one rotation.
// Requests settled at once (size zero, too large, no-op free) go straight to
// the done state. Reset clears every cell to free at once. A stalled result
// holds in the output register while the next word is taken and worked on;
// the next word's result waits in done until the output register frees.
module block_table_heap_allocator
  import bth_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bth_in_if.sink   in_i,
  bth_out_if.source out_o,
  bth_cfg_if.sink  cfg_i
);

  `include "assert_macros.svh"

  // BLOCK_BYTES is taken as a power of two; the byte offset is a shift.
  localparam int unsigned SH = $clog2(BLOCK_BYTES);
  localparam int unsigned PW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NW = $clog2(MAX_BLOCKS + 1);
  localparam logic [PW-1:0] LAST = PW'(MAX_BLOCKS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_COUNT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Registers.
  logic [31:0]   base_q;
  logic [10:0]   total_q;
  logic [2:0]    state_q, state_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [NW-1:0] need_q, need_d;
  logic [NW-1:0] run_len_q, run_len_d;
  logic [PW-1:0] run_start_q, run_start_d;
  logic [PW-1:0] start_q, start_d;
  logic          found_q, found_d;
  logic [PW-1:0] idx_q, idx_d;
  logic          active_q, active_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [31:0]   res_alloc_q, res_alloc_d;
  logic [31:0]   res_used_q, res_used_d;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [31:0]   out_alloc_q;
  logic [31:0]   out_used_q;

  // Ring of cells.
  entry_t cell_q [MAX_BLOCKS];
  entry_t head_new;
  logic   shift;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    entry_t cell_in;
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_mid
      assign cell_in = cell_q[k+1];
    end
    bth_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .entry_i(cell_in),
      .entry_o(cell_q[k])
    );
  end

  // Table size in use is the block count register capped at MAX_BLOCKS.
  logic [NW-1:0] n_use;
  always_comb begin
    if (32'(total_q) > 32'(MAX_BLOCKS)) begin
      n_use = NW'(MAX_BLOCKS);
    end else begin
      n_use = NW'(total_q);
    end
  end

  entry_t head;
  logic   in_range;
  assign head     = cell_q[0];
  assign in_range = (NW'(ptr_q) < n_use);

  // Request decode.
  logic [32:0] need_full;
  logic [31:0] free_off;
  logic [31:0] idx_full;
  assign need_full = (33'(in_i.size_bytes) + 33'(BLOCK_BYTES - 1)) >> SH;
  assign free_off  = in_i.address - base_q;
  assign idx_full  = free_off >> SH;

  // Mark offset within the run being allocated.
  logic [PW:0] mark_off;
  assign mark_off = {1'b0, ptr_q} - {1'b0, start_q};

  logic [NW-1:0] run_next;
  assign run_next = run_len_q + NW'(1);

  logic [63:0] bytes64;
  assign bytes64 = 64'(cnt_q) << SH;

  logic in_fire, out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    need_d       = need_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    start_d      = start_q;
    found_d      = found_q;
    idx_d        = idx_q;
    active_d     = active_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_alloc_d  = res_alloc_q;
    res_used_d   = res_used_q;
    head_new     = head;
    shift        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_OK;
          res_alloc_d  = '0;
          res_used_d   = '0;
          ptr_d        = '0;
          unique case (in_i.func)
            FUNC_ALLOC: begin
              if (in_i.size_bytes == '0) begin
                res_status_d = ST_INVALID;
                state_d      = S_DONE;
              end else if (need_full > 33'(n_use)) begin
                res_status_d = ST_NOMEM;
                state_d      = S_DONE;
              end else begin
                need_d    = NW'(need_full);
                run_len_d = '0;
                found_d   = 1'b0;
                state_d   = S_SCAN;
              end
            end
            FUNC_FREE: begin
              if (in_i.address == '0 || idx_full >= 32'(n_use)) begin
                state_d = S_DONE;
              end else begin
                idx_d    = PW'(idx_full);
                active_d = 1'b0;
                state_d  = S_FREE;
              end
            end
            FUNC_QUERY: begin
              cnt_d   = '0;
              state_d = S_COUNT;
            end
            default: begin
              res_status_d = ST_INVALID;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        shift = 1'b1;
        ptr_d = ptr_q + PW'(1);
        if (in_range && !found_q) begin
          if (!head.taken) begin
            if (run_len_q == '0) begin
              run_start_d = ptr_q;
            end
            run_len_d = run_next;
            if (run_next == need_q) begin
              found_d = 1'b1;
              start_d = (run_len_q == '0) ? ptr_q : run_start_q;
            end
          end else begin
            run_len_d = '0;
          end
        end
        if (ptr_q == LAST) begin
          ptr_d = '0;
          if (found_d) begin
            state_d = S_MARK;
          end else begin
            res_status_d = ST_NOMEM;
            state_d      = S_DONE;
          end
        end
      end
      S_MARK: begin
        shift = 1'b1;
        ptr_d = ptr_q + PW'(1);
        if (ptr_q >= start_q && 32'(mark_off) < 32'(need_q)) begin
          head_new.taken    = 1'b1;
          head_new.first    = (ptr_q == start_q);
          head_new.has_next = (32'(mark_off) + 32'd1 != 32'(need_q));
        end
        if (ptr_q == LAST) begin
          ptr_d       = '0;
          res_alloc_d = base_q + (32'(start_q) << SH);
          state_d     = S_DONE;
        end
      end
      S_FREE: begin
        shift = 1'b1;
        ptr_d = ptr_q + PW'(1);
        if ((active_q || ptr_q == idx_q) && in_range) begin
          head_new = '0;
          active_d = head.has_next;
        end else begin
          active_d = 1'b0;
        end
        if (ptr_q == LAST) begin
          ptr_d   = '0;
          state_d = S_DONE;
        end
      end
      S_COUNT: begin
        shift = 1'b1;
        ptr_d = ptr_q + PW'(1);
        if (in_range && head.taken) begin
          cnt_d = cnt_q + NW'(1);
        end
        if (ptr_q == LAST) begin
          ptr_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The used-bytes figure is formed from the final count while waiting in DONE.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      active_q    <= 1'b0;
      run_len_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      total_q     <= BLOCK_COUNT_RST;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      found_q   <= found_d;
      active_q  <= active_d;
      run_len_q <= run_len_d;
      cnt_q     <= cnt_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_BASE_ADDRESS) begin
          base_q <= cfg_i.data;
        end else if (cfg_i.index == REG_BLOCK_COUNT) begin
          total_q <= cfg_i.data[10:0];
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [31:0] used_fin;
  assign used_fin = (|bytes64[63:32]) ? 32'hFFFF_FFFF : bytes64[31:0];

  always_ff @(posedge clk_i) begin
    need_q       <= need_d;
    run_start_q  <= run_start_d;
    start_q      <= start_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_alloc_q  <= res_alloc_d;
    res_used_q   <= (state_q == S_COUNT && state_d == S_DONE) ? 32'hFFFF_FFFF : res_used_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_alloc_q  <= res_alloc_q;
      out_used_q   <= (res_used_q == 32'hFFFF_FFFF) ? used_fin : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.alloc_address = out_alloc_q;
  assign out_o.used_bytes    = out_used_q;

  // A taken request always leaves idle.
  `BTH_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, state_q != S_IDLE)
  // Marking only happens once a run has been found.
  `BTH_ASSERT_NOW(a_mark_found, clk_i, rst_ni, state_q == S_MARK, found_q)
  // The ring is aligned (pointer at zero) outside of a rotation.
  `BTH_ASSERT_NOW(a_ring_aligned, clk_i, rst_ni,
                  state_q == S_IDLE || state_q == S_DONE, ptr_q == '0)

endmodule
